// File: rtl/fbc64_pkg.sv
// Shared types, constants and round function of the four-branch Feistel cipher.
package fbc64_pkg;

   localparam int BRANCH_W       = 16;
   localparam int BRANCHES       = 4;
   localparam int BLOCK_W        = BRANCH_W * BRANCHES;
   localparam int KEY_REGS       = 8;
   localparam int KEY_IDX_W      = $clog2(KEY_REGS);
   localparam int ROUNDS_DEFAULT = 8;
   localparam int ROT_DATA       = 9;
   localparam int ROT_KEY        = 11;
   localparam int CSR_DATA_W     = 32;
   localparam int CSR_ADDR_W     = KEY_IDX_W + 2;

   // Operation codes carried with each request
   localparam logic ACT_ENCRYPT = 1'b0;
   localparam logic ACT_DECRYPT = 1'b1;

   typedef logic [BRANCH_W-1:0] branch_type;
   typedef logic [BLOCK_W-1:0]  block_type;

   // Per-cell control handed from one cell to the next
   typedef struct packed {
      logic valid;
      logic action;
   } stage_ctl_type;

   // Rotate left by the fixed data rotation
   function automatic branch_type rotl_data(input branch_type x);
      return {x[BRANCH_W-1-ROT_DATA:0], x[BRANCH_W-1:BRANCH_W-ROT_DATA]};
   endfunction

   // Rotate right by the fixed key rotation
   function automatic branch_type rotr_key(input branch_type x);
      return {x[ROT_KEY-1:0], x[BRANCH_W-1:ROT_KEY]};
   endfunction

   // Compute t = p3 ^ F(p0, p1, p2, key)
   function automatic branch_type round_t(input block_type blk, input branch_type key);
      branch_type p0;
      branch_type p1;
      branch_type p2;
      branch_type p3;
      branch_type mix;
      p0  = blk[0*BRANCH_W +: BRANCH_W];
      p1  = blk[1*BRANCH_W +: BRANCH_W];
      p2  = blk[2*BRANCH_W +: BRANCH_W];
      p3  = blk[3*BRANCH_W +: BRANCH_W];
      mix = rotr_key(key) ^ p0 ^ p1 ^ p2;
      return p3 ^ rotl_data(p0) ^ rotl_data(p1) ^ rotl_data(p2) ^ ~mix;
   endfunction

endpackage

// File: rtl/fbc64_cell.sv
// One round cell: applies a cipher round and holds the result for the next cell.
module fbc64_cell #(
   parameter bit LAST = 1'b0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  fbc64_pkg::stage_ctl_type up_ctl,
   input  fbc64_pkg::block_type    up_block,
   input  fbc64_pkg::branch_type   key_enc,
   input  fbc64_pkg::branch_type   key_dec,
   output logic                   up_ready,
   output fbc64_pkg::stage_ctl_type dn_ctl,
   output fbc64_pkg::block_type    dn_block,
   input  logic                   dn_ready
);
   import fbc64_pkg::*;

   stage_ctl_type ctl_ff;
   stage_ctl_type ctl_in;
   block_type     block_ff;
   block_type     block_in;
   branch_type    key;
   branch_type    t;
   branch_type    p0;
   branch_type    p1;
   branch_type    p2;

   // Take a new request when empty or when the held one moves on
   assign up_ready = !ctl_ff.valid || dn_ready;

   // Pick the key for this round by direction
   assign key = (up_ctl.action == ACT_DECRYPT) ? key_dec : key_enc;

   // Compute the round and arrange the branches
   always_comb begin
      p0 = up_block[0*BRANCH_W +: BRANCH_W];
      p1 = up_block[1*BRANCH_W +: BRANCH_W];
      p2 = up_block[2*BRANCH_W +: BRANCH_W];
      t  = round_t(up_block, key);
      if (LAST) begin
         block_in = {t, p2, p1, p0};
      end else if (up_ctl.action == ACT_DECRYPT) begin
         block_in = {p2, p1, p0, t};
      end else begin
         block_in = {p0, t, p2, p1};
      end
   end

   // Advance control when the cell takes a request or drains
   always_comb begin
      ctl_in = ctl_ff;
      if (up_ready) begin
         ctl_in = up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   // Hold the payload unless a new request arrives
   always_ff @(posedge clock) begin
      if (up_ready && up_ctl.valid) begin
         block_ff <= block_in;
      end
   end

   assign dn_ctl   = ctl_ff;
   assign dn_block = block_ff;

endmodule

// File: rtl/feistel_block_cipher_64_top.sv
// Each round cell holds one register, so a request passes one register per round cell on
// its way to the response. Throughput: one request per cycle unless rsp_stall fills the
// chain; each round cell is a register stage with its own ready, so bubbles collapse and
// a new request enters while a finished response waits.
// Reset: synchronous, active high; clears all cell valid bits and the round keys to zero.
// Top level of the four-branch Feistel block cipher with APB key registers.
module feistel_block_cipher_64_top #(
   parameter int ROUNDS = fbc64_pkg::ROUNDS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_action,
   input  logic [fbc64_pkg::BLOCK_W-1:0]        req_block_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [fbc64_pkg::BLOCK_W-1:0]        rsp_block_out,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fbc64_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [fbc64_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [fbc64_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);
   import fbc64_pkg::*;

   branch_type    keys_ff [KEY_REGS];
   logic [KEY_IDX_W-1:0] csr_idx;
   logic          csr_wr;

   stage_ctl_type ctl   [ROUNDS+1];
   block_type     blk   [ROUNDS+1];
   logic          ready [ROUNDS+1];

   // Register file: key index from the word address
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = {{(CSR_DATA_W-BRANCH_W){1'b0}}, keys_ff[csr_idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KEY_REGS; k++) begin
            keys_ff[k] <= '0;
         end
      end else if (csr_wr) begin
         keys_ff[csr_idx] <= csr_pwdata[BRANCH_W-1:0];
      end
   end

   // Feed the chain from the request channel
   assign ctl[0].valid = req_valid;
   assign ctl[0].action = req_action;
   assign blk[0]       = req_block_in;
   assign req_stall    = !ready[0];

   // Chain of round cells
   for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
      localparam int ENC_IDX = i;
      localparam int DEC_IDX = ROUNDS - 1 - i;
      fbc64_cell #(
         .LAST (i == ROUNDS - 1)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_ctl   (ctl[i]),
         .up_block (blk[i]),
         .key_enc  (keys_ff[ENC_IDX]),
         .key_dec  (keys_ff[DEC_IDX]),
         .up_ready (ready[i]),
         .dn_ctl   (ctl[i+1]),
         .dn_block (blk[i+1]),
         .dn_ready (ready[i+1])
      );
   end

   // Drive the response channel from the last cell
   assign ready[ROUNDS]  = !rsp_stall;
   assign rsp_valid      = ctl[ROUNDS].valid;
   assign rsp_block_out  = blk[ROUNDS];

endmodule

// File: rtl/fbc64_checker.sv
// Port-level checker for the Feistel cipher top level, bound to every instance.
module fbc64_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [fbc64_pkg::BLOCK_W-1:0] rsp_block_out
);

   // Keep a stalled response valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled response dropped");

   // Keep a stalled response payload stable
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_block_out))
      else $error("stalled response payload changed");

   // Stall requests only when the output side is backed up
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while output drains");

   // No response and no request stall right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("response or stall seen right after reset");

endmodule

bind feistel_block_cipher_64_top fbc64_checker u_fbc64_checker (.*);

// File: tb/sv/feistel_block_cipher_64_top_test.sv
// Self-checking testbench for the four-branch Feistel block cipher top level.
module feistel_block_cipher_64_top_test;
   import fbc64_pkg::*;

   localparam int     ROUNDS      = ROUNDS_DEFAULT;
   localparam int     PHASE_ITEMS = 276;
   localparam int     HOLD_CYCLES = 150;
   localparam int     HOLD_AFTER  = 600;
   localparam int     IDLE_PCT    = 35;
   localparam longint CYCLE_LIMIT = 200000;

   // Corner blocks sent both ways with the reset keys
   localparam block_type CORNERS [10] = '{
      64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
      64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000,
      64'h0000_0000_0000_FFFF, 64'h0000_0000_FFFF_0000,
      64'h0000_FFFF_0000_0000, 64'hFFFF_0000_0000_0000
   };

   // Predicts cipher output and holds the blocks still owed by the block
   class block_ledger;
      branch_type keys [KEY_REGS];
      block_type  owed_q [$];
      int         accepted;
      int         checked;
      int         enc_seen;
      int         dec_seen;
      int         mismatches;

      function new();
         foreach (keys[i]) keys[i] = '0;
         accepted   = 0;
         checked    = 0;
         enc_seen   = 0;
         dec_seen   = 0;
         mismatches = 0;
      endfunction

      function void set_key(int idx, branch_type value);
         keys[idx] = value;
      endfunction

      function branch_type rol(branch_type x, int s);
         return (x << s) | (x >> (BRANCH_W - s));
      endfunction

      function branch_type ror(branch_type x, int s);
         return (x >> s) | (x << (BRANCH_W - s));
      endfunction

      // Run all rounds on one block with the current keys
      function block_type predict(logic act, block_type blk);
         branch_type b [BRANCHES];
         branch_type f;
         branch_type t;
         block_type  res;
         int         r;
         for (int i = 0; i < BRANCHES; i++) b[i] = blk[i*BRANCH_W +: BRANCH_W];
         for (int i = 0; i < ROUNDS; i++) begin
            r = (act == ACT_DECRYPT) ? (ROUNDS - 1 - i) : i;
            f = rol(b[0], ROT_DATA) ^ rol(b[1], ROT_DATA) ^ rol(b[2], ROT_DATA)
                ^ ~(ror(keys[r % KEY_REGS], ROT_KEY) ^ b[0] ^ b[1] ^ b[2]);
            t = b[3] ^ f;
            if (i == ROUNDS - 1) begin
               b[3] = t;
            end else if (act == ACT_ENCRYPT) begin
               b[3] = b[0];
               b[0] = b[1];
               b[1] = b[2];
               b[2] = t;
            end else begin
               b[3] = b[2];
               b[2] = b[1];
               b[1] = b[0];
               b[0] = t;
            end
         end
         res = '0;
         for (int i = 0; i < BRANCHES; i++) res[i*BRANCH_W +: BRANCH_W] = b[i];
         return res;
      endfunction

      function void note_request(logic act, block_type blk);
         owed_q.push_back(predict(act, blk));
         accepted++;
         if (act == ACT_DECRYPT) dec_seen++;
         else enc_seen++;
      endfunction

      function void compare(string what, block_type want, block_type got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch on %s: expected %h, got %h", what, want, got);
         end
      endfunction

      function void check_block(block_type got);
         if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("response %h arrived with none owed", got);
            return;
         end
         compare("block_out", owed_q.pop_front(), got);
         checked++;
      endfunction

      function int owed();
         return owed_q.size();
      endfunction
   endclass

   logic                  clock;
   logic                  reset         = 1'b1;
   logic                  req_valid     = 1'b0;
   logic                  req_stall;
   logic                  req_action    = ACT_ENCRYPT;
   block_type             req_block_in  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall     = 1'b0;
   block_type             rsp_block_out;
   logic                  csr_psel      = 1'b0;
   logic                  csr_penable   = 1'b0;
   logic                  csr_pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr     = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata    = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   block_ledger board = new();
   bit          no_idle = 1'b0;
   bit          hold_seen = 1'b0;
   int          key_settings = 1;
   longint      cycles = 0;

   feistel_block_cipher_64_top #(.ROUNDS(ROUNDS)) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_block_in  (req_block_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_block_out (rsp_block_out),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Abort a hung run
   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles, %0d responses still owed", cycles, board.owed());
      $display("CHECKS FAILED");
      $finish;
   end

   // Offer one request, hold it until accepted, then idle at random
   task automatic send_req(logic act, block_type blk);
      req_valid    <= 1'b1;
      req_action   <= act;
      req_block_in <= blk;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_request(act, blk);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Write one round key through a setup and an access phase
   task automatic csr_write(int idx, logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      board.set_key(idx, data[BRANCH_W-1:0]);
   endtask

   // Read one round key back and compare with the kept value
   task automatic csr_read_check(int idx);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      board.compare($sformatf("round_key_%0d readback", idx),
                    block_type'(board.keys[idx]), block_type'(csr_prdata));
   endtask

   // Read back every key, then drop the bus
   task automatic verify_keys();
      for (int i = 0; i < KEY_REGS; i++) csr_read_check(i);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Mix of random blocks, round trips and sparse or dense patterns
   task automatic run_random(int n);
      block_type x;
      block_type y;
      int        sent;
      int        pick;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(99);
         x    = {$urandom, $urandom};
         if (pick < 20) begin
            y = board.predict(ACT_ENCRYPT, x);
            send_req(ACT_ENCRYPT, x);
            send_req(ACT_DECRYPT, y);
            sent += 2;
         end else if (pick < 30) begin
            y = board.predict(ACT_DECRYPT, x);
            send_req(ACT_DECRYPT, x);
            send_req(ACT_ENCRYPT, y);
            sent += 2;
         end else if (pick < 40) begin
            x = block_type'(1) << $urandom_range(BLOCK_W - 1);
            if ($urandom_range(1)) x = ~x;
            send_req(logic'($urandom_range(1)), x);
            sent++;
         end else begin
            send_req(logic'($urandom_range(1)), x);
            sent++;
         end
      end
      req_valid <= 1'b0;
   endtask

   // Wait until every owed response is back, then let the pipe settle
   task automatic drain();
      while (board.owed() != 0) @(posedge clock);
      repeat (ROUNDS + 4) @(posedge clock);
   endtask

   // Check responses and drive the stall, with one long hold-off
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
            board.check_block(rsp_block_out);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_seen && board.accepted >= HOLD_AFTER) begin
            hold_seen = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   initial begin : main_seq
      logic [CSR_DATA_W-1:0] kval;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Keys come up zero after reset
      verify_keys();

      // Corner blocks, both operations, reset keys
      foreach (CORNERS[i]) begin
         send_req(ACT_ENCRYPT, CORNERS[i]);
         send_req(ACT_DECRYPT, CORNERS[i]);
      end
      req_valid <= 1'b0;
      drain();

      // All keys at maximum, with the upper data bits set as well
      for (int i = 0; i < KEY_REGS; i++) csr_write(i, 32'hFFFF_FFFF);
      verify_keys();
      key_settings++;
      run_random(PHASE_ITEMS);
      drain();

      // Fully random key words
      for (int i = 0; i < KEY_REGS; i++) csr_write(i, $urandom);
      verify_keys();
      key_settings++;
      run_random(PHASE_ITEMS);
      drain();

      // Walking-bit keys under a burst with no random idling on either side
      for (int i = 0; i < KEY_REGS; i++) begin
         kval = {16'hA5A5, 16'h0001 << (i * 2)};
         csr_write(i, kval);
      end
      verify_keys();
      key_settings++;
      no_idle = 1'b1;
      run_random(PHASE_ITEMS);
      no_idle = 1'b0;
      drain();

      // Zero keys written explicitly, junk in the upper bits
      for (int i = 0; i < KEY_REGS; i++) begin
         kval = {16'($urandom_range(16'hFFFF, 1)), 16'h0000};
         csr_write(i, kval);
      end
      verify_keys();
      key_settings++;
      run_random(PHASE_ITEMS);
      drain();

      // Random keys again
      for (int i = 0; i < KEY_REGS; i++) csr_write(i, $urandom);
      verify_keys();
      key_settings++;
      run_random(PHASE_ITEMS);
      drain();

      $display("Covered %0d requests (%0d encrypt, %0d decrypt) over %0d key settings;",
               board.accepted, board.enc_seen, board.dec_seen, key_settings);
      $display("%0d responses checked, %0d-cycle response hold-off %0s, %0d mismatches",
               board.checked, HOLD_CYCLES, hold_seen ? "seen" : "missed", board.mismatches);
      if (board.mismatches == 0 && board.owed() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/fbc64_pkg.sv
rtl/fbc64_cell.sv
rtl/feistel_block_cipher_64_top.sv
rtl/fbc64_checker.sv
tb/sv/feistel_block_cipher_64_top_test.sv
